>>> rtl/spl_pkg.sv
package spl_pkg;

  typedef struct packed {
    logic signed [31:0] command_increment;
    logic [30:0]        sensor_position;
    logic               sensor_valid;
  } spl_in_t;

  typedef struct packed {
    logic signed [31:0] speed_reference;
    logic signed [31:0] filtered_increment;
    logic signed [31:0] feedback_increment;
    logic signed [31:0] error_total;
    logic signed [31:0] command_total;
    logic signed [31:0] feedback_total;
    logic [9:0]         active_countdown;
  } spl_out_t;

  typedef struct packed {
    logic        bypass;
    logic [9:0]  length;
    logic [30:0] counts;
    logic [31:0] gain;
    logic [31:0] upper;
    logic [31:0] lower;
  } spl_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, read window entry
    logic front;     // feedback, window update, start divide
    logic div_step;  // one quotient bit
    logic accum;     // divide done: totals, remainder, start multiply
    logic mul_step;  // one partial product
    logic finish;    // shift, clamp, output register
  } spl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic mul_last;
  } spl_sts_t;

  localparam logic [2:0] ADDR_BYPASS = 3'd0;
  localparam logic [2:0] ADDR_LENGTH = 3'd1;
  localparam logic [2:0] ADDR_COUNTS = 3'd2;
  localparam logic [2:0] ADDR_GAIN   = 3'd3;
  localparam logic [2:0] ADDR_UPPER  = 3'd4;
  localparam logic [2:0] ADDR_LOWER  = 3'd5;

endpackage

>>> rtl/spl_ctrl.sv
module spl_ctrl
  import spl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  spl_sts_t sts_i,
  output spl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_FRONT, S_DIV, S_ACC, S_MUL, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // the output register takes the result only once the previous one is gone
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.front    = (state_q == S_FRONT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.accum    = (state_q == S_ACC);
    cmd_o.mul_step = (state_q == S_MUL);
    cmd_o.finish   = (state_q == S_FIN) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_FRONT;
      S_FRONT: state_d = S_DIV;
      S_DIV:   if (sts_i.div_last) state_d = S_ACC;
      S_ACC:   state_d = S_MUL;
      S_MUL:   if (sts_i.mul_last) state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> out_free) else $error("result overwritten");

endmodule

>>> rtl/spl_datapath.sv
module spl_datapath
  import spl_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 512
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spl_cfg_t cfg_i,
  input  spl_in_t  in_i,
  input  spl_cmd_t cmd_i,
  output spl_sts_t sts_o,
  output spl_out_t out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned LW = $clog2(WINDOW_DEPTH + 1);

  // entries written so far always form a prefix of the store; anything at or
  // above the fill mark has never been written and reads as zero
  logic [31:0] mem_q [WINDOW_DEPTH];
  logic [AW:0] fill_q;
  logic [31:0] rd_q;
  logic        rd_ok_q;

  logic [AW-1:0] idx_q;
  logic          full_q;
  logic signed [47:0] wsum_q;
  logic signed [47:0] rem_q;
  logic [9:0]    hold_q;
  logic [30:0]   prev_q;
  logic [31:0]   rsum_q, msum_q, esum_q;

  spl_in_t       req_q;
  logic [LW-1:0] len_q;
  logic          byp_q;
  logic signed [31:0] fb_q;
  logic signed [31:0] filt_q;

  // sign-magnitude divider
  logic [48:0] dnum_q;   // |total|, shifted out
  logic [48:0] drem_q;   // partial remainder
  logic        dneg_q;
  logic [5:0]  dcnt_q;

  // shift-add multiplier, 32 steps
  logic [63:0] pacc_q;
  logic [31:0] mcand_q;   // |err|
  logic [31:0] mplier_q;
  logic        mneg_q;
  logic [5:0]  mcnt_q;

  // clamped window length
  logic [LW-1:0] len_c;
  always_comb begin
    if (cfg_i.length == 10'd0) len_c = LW'(1);
    else if ({22'd0, cfg_i.length} > 32'(WINDOW_DEPTH)) len_c = LW'(WINDOW_DEPTH);
    else len_c = LW'(cfg_i.length);
  end

  logic [AW-1:0] ridx_c;
  assign ridx_c = ({{(32-AW){1'b0}}, idx_q} >= 32'(WINDOW_DEPTH)) ? '0 : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q  <= mem_q[ridx_c];
      req_q <= in_i;
      len_q <= len_c;
      byp_q <= cfg_i.bypass || (len_c == LW'(1));
    end
    if (cmd_i.front && !byp_q) mem_q[ridx_c] <= req_q.command_increment;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_ok_q <= 1'b0;
    else if (cmd_i.load) rd_ok_q <= full_q && ({1'b0, ridx_c} < fill_q);
  end

  // front stage combinational values
  logic [30:0] pos_c;
  logic signed [32:0] diff_c, half_c, cnt_c, fbw_c;
  logic signed [47:0] cmd48_c, old48_c, wsum_new_c, total_c;
  assign pos_c  = req_q.sensor_valid ? req_q.sensor_position : 31'd0;
  assign diff_c = $signed({2'b00, pos_c}) - $signed({2'b00, prev_q});
  assign half_c = $signed({3'b000, cfg_i.counts[30:1]});
  assign cnt_c  = $signed({2'b00, cfg_i.counts});
  always_comb begin
    if (diff_c > half_c) fbw_c = diff_c - cnt_c;
    else if (diff_c < -half_c) fbw_c = diff_c + cnt_c;
    else fbw_c = diff_c;
  end
  assign cmd48_c    = 48'(req_q.command_increment);
  assign old48_c    = rd_ok_q ? 48'($signed(rd_q)) : 48'sd0;
  assign wsum_new_c = wsum_q - old48_c + cmd48_c;
  assign total_c    = wsum_new_c + rem_q;

  logic [AW:0] idx_inc_c;
  assign idx_inc_c = {1'b0, ridx_c} + 1'b1;

  // divider step
  logic [48:0] dtrial_c;
  logic [49:0] dsub_c;
  assign dtrial_c = {drem_q[47:0], dnum_q[48]};
  assign dsub_c   = {1'b0, dtrial_c} - {{(50-LW){1'b0}}, len_q};

  logic [48:0] q_mag_c;
  logic signed [48:0] q_c, r_c;
  assign q_mag_c = dnum_q;   // quotient bits shifted in at bottom
  assign q_c = dneg_q ? -$signed(q_mag_c) : $signed(q_mag_c);
  assign r_c = dneg_q ? -$signed(drem_q) : $signed(drem_q);

  assign sts_o.div_last = (dcnt_q == 6'd48);
  assign sts_o.mul_last = (mcnt_q == 6'd31);

  // product sign, floor shift, clamp
  logic signed [64:0] prod_c;
  logic signed [40:0] spd_c;
  logic signed [31:0] spd_sat_c;
  assign prod_c = mneg_q ? -$signed({1'b0, pacc_q}) : $signed({1'b0, pacc_q});
  assign spd_c  = prod_c[64:24];
  always_comb begin
    if (spd_c > 41'($signed(cfg_i.upper))) spd_sat_c = $signed(cfg_i.upper);
    else if (spd_c < 41'($signed(cfg_i.lower))) spd_sat_c = $signed(cfg_i.lower);
    else spd_sat_c = spd_c[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      full_q <= 1'b0;
      wsum_q <= '0;
      rem_q  <= '0;
      hold_q <= '0;
      prev_q <= '0;
      rsum_q <= '0;
      msum_q <= '0;
      esum_q <= '0;
      dcnt_q <= '0;
      mcnt_q <= '0;
      fb_q   <= '0;
      filt_q <= '0;
      dnum_q <= '0;
      drem_q <= '0;
      dneg_q <= 1'b0;
    end else begin
      if (cmd_i.front) begin
        prev_q <= pos_c;
        fb_q   <= fbw_c[31:0];
        dcnt_q <= '0;
        if (byp_q) begin
          filt_q <= req_q.command_increment;
          hold_q <= (req_q.command_increment != 0) ? 10'd1 : 10'd0;
          wsum_q <= cmd48_c * 48'(len_q);
          dnum_q <= '0;
          drem_q <= '0;
          dneg_q <= 1'b0;
        end else begin
          if (idx_inc_c > fill_q) fill_q <= idx_inc_c;
          if ({{(31-AW){1'b0}}, idx_inc_c} >= 32'(len_q)) begin
            idx_q  <= '0;
            full_q <= 1'b1;
          end else begin
            idx_q <= idx_inc_c[AW-1:0];
          end
          wsum_q <= wsum_new_c;
          dneg_q <= total_c[47];
          dnum_q <= total_c[47] ? 49'(-{total_c[47], total_c})
                                : {1'b0, total_c};
          drem_q <= '0;
          if (req_q.command_increment != 0) hold_q <= 10'(len_q);
          else if (hold_q != 0) hold_q <= hold_q - 1'b1;
        end
      end
      if (cmd_i.div_step) begin
        if (byp_q) begin
          dcnt_q <= 6'd48;
        end else begin
          dcnt_q <= dcnt_q + 1'b1;
          if (!dsub_c[49]) begin
            drem_q <= dsub_c[48:0];
            dnum_q <= {dnum_q[47:0], 1'b1};
          end else begin
            drem_q <= dtrial_c;
            dnum_q <= {dnum_q[47:0], 1'b0};
          end
        end
      end
      if (cmd_i.accum) begin
        if (!byp_q) begin
          filt_q <= q_c[31:0];
          rem_q  <= r_c[47:0];
        end
        rsum_q <= rsum_q + (byp_q ? req_q.command_increment : q_c[31:0]);
        msum_q <= msum_q + fb_q;
        esum_q <= byp_q ? esum_q + req_q.command_increment - fb_q
                        : esum_q + q_c[31:0] - fb_q;
        mcnt_q <= '0;
      end
      if (cmd_i.mul_step) mcnt_q <= mcnt_q + 1'b1;
    end
  end

  // multiplier operands are loaded once the error total is settled
  logic accum_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) accum_d_q <= 1'b0;
    else accum_d_q <= cmd_i.accum;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      pacc_q <= '0;
    end
    if (cmd_i.mul_step) begin
      if (accum_d_q) begin
        // first step: load operands and add bit 0
        mneg_q   <= esum_q[31];
        mcand_q  <= esum_q[31] ? 32'(-esum_q) : esum_q;
        mplier_q <= cfg_i.gain >> 1;
        pacc_q   <= cfg_i.gain[0] ? {1'b0, 31'd0,
                      (esum_q[31] ? 32'(-esum_q) : esum_q)} << 0 : 64'd0;
      end else begin
        mplier_q <= mplier_q >> 1;
        if (mplier_q[0]) pacc_q <= pacc_q + ({32'd0, mcand_q} << mcnt_q);
      end
    end
    if (cmd_i.finish) begin
      out_o.speed_reference    <= spd_sat_c;
      out_o.filtered_increment <= filt_q;
      out_o.feedback_increment <= fb_q;
      out_o.error_total        <= esum_q;
      out_o.command_total      <= rsum_q;
      out_o.feedback_total     <= msum_q;
      out_o.active_countdown   <= hold_q;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.front |=> ({{(32-AW){1'b0}}, idx_q} < 32'(WINDOW_DEPTH)))
    else $error("window index out of range");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (len_q != '0)) else $error("divide by zero");
  a_err_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accum |=> (esum_q == $past(esum_q) + (byp_q ? $past(req_q.command_increment)
      : $past(q_c[31:0])) - $past(fb_q))) else $error("error total mismatch");

endmodule

>>> rtl/servo_position_loop.sv
// Proportional servo position loop with a moving average on the command.
// One request in flight at a time: from acceptance to the next acceptance
// a request goes through capture, one window update, a 49-step restoring
// divide by the window length, a 32-step shift-add multiply by the gain,
// then clamp and output register. In bypass the divide is skipped: its
// counter jumps to the end. The result waits in the output register; the next
// request is taken once it is loaded, so a stalled result adds its stall.
// The averaging window lives in a WINDOW_DEPTH x 32 memory with a fill mark,
// so no clearing pass is needed after reset.
module servo_position_loop
  import spl_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  spl_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output spl_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  spl_cfg_t cfg_q;
  spl_cmd_t cmd;
  spl_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass <= 1'b0;
      cfg_q.length <= 10'd320;
      cfg_q.counts <= 31'd16777216;
      cfg_q.gain   <= 32'd25872576;
      cfg_q.upper  <= 32'd41177483;
      cfg_q.lower  <= 32'hFD8BAE75;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        ADDR_BYPASS: cfg_q.bypass <= pwdata[0];
        ADDR_LENGTH: cfg_q.length <= pwdata[9:0];
        ADDR_COUNTS: cfg_q.counts <= pwdata[30:0];
        ADDR_GAIN:   cfg_q.gain   <= pwdata;
        ADDR_UPPER:  cfg_q.upper  <= pwdata;
        ADDR_LOWER:  cfg_q.lower  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ADDR_BYPASS: prdata = {31'd0, cfg_q.bypass};
      ADDR_LENGTH: prdata = {22'd0, cfg_q.length};
      ADDR_COUNTS: prdata = {1'b0, cfg_q.counts};
      ADDR_GAIN:   prdata = cfg_q.gain;
      ADDR_UPPER:  prdata = cfg_q.upper;
      ADDR_LOWER:  prdata = cfg_q.lower;
      default:     prdata = '0;
    endcase
  end

  spl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spl_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_data_o)
  );

endmodule
